/* hdl/relay_fire_scheduler_top_macros.svh */
// Assertion macros for the relay fire scheduler.
// Used by files that declare clk_i and rst_ni; no other dependencies.
`ifndef RELAY_FIRE_SCHEDULER_TOP_MACROS_SVH
`define RELAY_FIRE_SCHEDULER_TOP_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define RFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication.
`define RFS_ASSERT_IMP(lbl, ante, cons, msg) \
  `RFS_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* hdl/rfs_pkg.sv */
// Shared constants, types and helpers for the relay fire scheduler.
// No dependencies; the interfaces, the cell and the top import this package.
package rfs_pkg;

  localparam int ENTRY_COUNT = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int CNT_W       = COUNT_WIDTH;
  localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CMP_W       = (IDX_W > 3) ? IDX_W : 3;
  localparam int DATE_W      = 9;
  localparam int HOUR_W      = 5;
  localparam int SLOT_W      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_PERIOD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_PRESENT = 2'd2;

  // request kinds
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // search token handed from cell to cell
  typedef struct packed {
    logic              go;
    logic              found;
    logic [DATE_W-1:0] best;
    logic [IDX_W-1:0]  sel;
  } tok_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              wr;
    logic              apply;
    logic [SLOT_W-1:0] slot;
    logic              valid;
    logic [DATE_W-1:0] date;
    logic [HOUR_W-1:0] start;
    logic [CNT_W-1:0]  cycle;
    logic [CNT_W-1:0]  on_len;
    logic [IDX_W-1:0]  sel;
    logic [DATE_W-1:0] today;
    logic [HOUR_W-1:0] hour;
  } cmd_t;

  // 16-bit field to counter width (truncate or zero-extend)
  function automatic logic [CNT_W-1:0] cnt_from16(input logic [15:0] v);
    logic [CNT_W-1:0] r;
    r = '0;
    for (int i = 0; i < CNT_W && i < 16; i++) begin
      r[i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] v);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = 0; i < SLOT_W && i < IDX_W; i++) begin
      r[i] = v[i];
    end
    return r;
  endfunction

  function automatic logic slot_hit(input logic [SLOT_W-1:0] s,
                                    input logic [IDX_W-1:0] idx);
    logic [CMP_W-1:0] a;
    logic [CMP_W-1:0] b;
    a = '0;
    b = '0;
    a[SLOT_W-1:0] = s;
    b[IDX_W-1:0]  = idx;
    return a == b;
  endfunction

endpackage

/* hdl/rfs_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on rfs_pkg for field widths.
interface rfs_in_if import rfs_pkg::*;;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [3:0]        now_month;
  logic [4:0]        now_day;
  logic [4:0]        now_hour;
  logic [SLOT_W-1:0] slot;
  logic              slot_valid;
  logic [4:0]        slot_day;
  logic [3:0]        slot_month;
  logic [4:0]        slot_start_hour;
  logic [15:0]       slot_cycle_len;
  logic [15:0]       slot_on_len;

  modport source (output valid, req_type, now_month, now_day, now_hour, slot, slot_valid,
                  slot_day, slot_month, slot_start_hour, slot_cycle_len, slot_on_len,
                  input ready);
  modport sink (input valid, req_type, now_month, now_day, now_hour, slot, slot_valid,
                slot_day, slot_month, slot_start_hour, slot_cycle_len, slot_on_len,
                output ready);
endinterface

interface rfs_out_if import rfs_pkg::*;;
  logic              valid;
  logic              ready;
  logic              fire;
  logic              entry_found;
  logic [SLOT_W-1:0] chosen_slot;

  modport source (output valid, fire, entry_found, chosen_slot, input ready);
  modport sink (input valid, fire, entry_found, chosen_slot, output ready);
endinterface

/* hdl/rfs_cell.sv */
// One schedule table entry with its run state and one stage of the search chain.
// Depends on rfs_pkg.
module rfs_cell import rfs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] my_idx_i,
  input  cmd_t             cmd_i,
  input  tok_t             tok_i,
  output tok_t             tok_o,
  output logic             fire_o
);

  logic              valid_q;
  logic [DATE_W-1:0] date_q;
  logic [HOUR_W-1:0] start_q;
  logic [CNT_W-1:0]  cyc_q;
  logic [CNT_W-1:0]  on_q;
  logic              run_q, run_d;
  logic [CNT_W-1:0]  cl_q, cl_d;
  logic [CNT_W-1:0]  ol_q, ol_d;
  logic [CNT_W-1:0]  cl_v, ol_v;
  tok_t              tok_q, tok_d;
  logic              hit_wr, hit_ap;

  assign hit_wr = cmd_i.wr && slot_hit(cmd_i.slot, my_idx_i);
  assign hit_ap = cmd_i.apply && (cmd_i.sel == my_idx_i);

  // search stage: latest date not after today, earlier cell wins ties
  always_comb begin
    tok_d = tok_i;
    if (tok_i.go && valid_q && (date_q <= cmd_i.today) &&
        (!tok_i.found || (date_q > tok_i.best))) begin
      tok_d.found = 1'b1;
      tok_d.best  = date_q;
      tok_d.sel   = my_idx_i;
    end
  end

  // run state
  always_comb begin
    run_d  = run_q;
    cl_d   = cl_q;
    ol_d   = ol_q;
    cl_v   = (cl_q == '0) ? cyc_q : cl_q;
    ol_v   = (cl_q == '0) ? on_q : ol_q;
    fire_o = 1'b0;
    if (hit_wr) begin
      run_d = 1'b0;
      cl_d  = '0;
      ol_d  = '0;
    end else if (hit_ap) begin
      if (run_q) begin
        if (ol_v != '0) begin
          fire_o = 1'b1;
          ol_d   = ol_v - CNT_W'(1);
        end else begin
          ol_d = ol_v;
        end
        cl_d = cl_v - CNT_W'(1);
      end else if (start_q == cmd_i.hour) begin
        run_d = 1'b1;
        cl_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      run_q   <= 1'b0;
      cl_q    <= '0;
      ol_q    <= '0;
      tok_q   <= '0;
    end else begin
      run_q <= run_d;
      cl_q  <= cl_d;
      ol_q  <= ol_d;
      tok_q <= tok_d;
      if (hit_wr) begin
        valid_q <= cmd_i.valid;
      end
    end
  end

  // entry contents, no reset
  always_ff @(posedge clk_i) begin
    if (hit_wr) begin
      date_q  <= cmd_i.date;
      start_q <= cmd_i.start;
      cyc_q   <= (cmd_i.cycle == '0) ? CNT_W'(1) : cmd_i.cycle;
      on_q    <= cmd_i.on_len;
    end
  end

  assign tok_o = tok_q;

endmodule

/* hdl/relay_fire_scheduler_top.sv */
// Relay fire scheduler: controller, configuration registers and the chain of table cells.
// Depends on rfs_pkg, rfs_if, rfs_cell and relay_fire_scheduler_top_macros.svh.
// Timing: writes, disabled and periodic ticks pass IDLE then DONE; date ticks pass IDLE, SCAN,
//   APPLY (when an entry is found) and DONE, the search token stepping one cell per cycle.
// Throughput: one item at a time; a new transfer is taken only once the last answer is loaded.
// Reset: asynchronous, active low; clears valid and run state and tick counter, resets registers.
`include "relay_fire_scheduler_top_macros.svh"

module relay_fire_scheduler_top import rfs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rfs_in_if.sink                req_i,
  rfs_out_if.source             rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_DONE
  } state_e;

  state_e            state_q;

  // configuration registers
  logic              enable_q;
  logic [15:0]       period_q;
  logic              relay_q;

  // periodic mode down-counter
  logic [CNT_W-1:0]  tick_q;

  // captured tick time and search launch
  logic [DATE_W-1:0] today_q;
  logic [HOUR_W-1:0] hour_q;
  logic              start_q;
  logic [IDX_W-1:0]  sel_q;

  // pending answer and output register
  logic              res_fire_q, res_found_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic              out_valid_q, out_fire_q, out_found_q;
  logic [SLOT_W-1:0] out_slot_q;

  logic              in_xfer;
  logic              out_xfer;
  cmd_t              cmd;
  tok_t              head_tok;
  tok_t              tok_in  [ENTRY_COUNT];
  tok_t              tok_out [ENTRY_COUNT];
  tok_t              tail_tok;
  logic [ENTRY_COUNT-1:0] go_vec;
  logic [ENTRY_COUNT-1:0] fire_vec;

  assign req_i.ready = (state_q == ST_IDLE);
  assign in_xfer     = req_i.valid && req_i.ready;
  assign out_xfer    = out_valid_q && rsp_o.ready;

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.fire        = out_fire_q;
  assign rsp_o.entry_found = out_found_q;
  assign rsp_o.chosen_slot = out_slot_q;

  // Configuration writes land directly; out-of-range indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      period_q <= '0;
      relay_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE:        enable_q <= cfg_data_i[0];
        CFG_FIXED_PERIOD:  period_q <= cfg_data_i[15:0];
        CFG_RELAY_PRESENT: relay_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Broadcast to the cells. A table write goes straight through on the request
  // transfer; apply is the single update cycle for the entry the search picked.
  always_comb begin
    cmd        = '0;
    cmd.wr     = in_xfer && (req_i.req_type == REQ_WRITE);
    cmd.apply  = (state_q == ST_APPLY);
    cmd.slot   = req_i.slot;
    cmd.valid  = req_i.slot_valid;
    cmd.date   = {req_i.slot_month, req_i.slot_day};
    cmd.start  = req_i.slot_start_hour;
    cmd.cycle  = cnt_from16(req_i.slot_cycle_len);
    cmd.on_len = cnt_from16(req_i.slot_on_len);
    cmd.sel    = sel_q;
    cmd.today  = today_q;
    cmd.hour   = hour_q;
  end

  // Search token enters cell 0 the cycle after a date-mode tick is taken.
  always_comb begin
    head_tok    = '0;
    head_tok.go = start_q;
  end

  for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign tok_in[g] = head_tok;
    end else begin : g_link
      assign tok_in[g] = tok_out[g-1];
    end

    rfs_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .my_idx_i (IDX_W'(g)),
      .cmd_i    (cmd),
      .tok_i    (tok_in[g]),
      .tok_o    (tok_out[g]),
      .fire_o   (fire_vec[g])
    );

    assign go_vec[g] = tok_out[g].go;
  end

  assign tail_tok = tok_out[ENTRY_COUNT-1];

  // Controller. Writes, disabled ticks and periodic ticks resolve in IDLE;
  // date ticks go through SCAN (token walk) and, if an entry is found, APPLY (run state update).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      start_q     <= 1'b0;
      sel_q       <= '0;
      today_q     <= '0;
      hour_q      <= '0;
      res_fire_q  <= 1'b0;
      res_found_q <= 1'b0;
      res_slot_q  <= '0;
      out_valid_q <= 1'b0;
      out_fire_q  <= 1'b0;
      out_found_q <= 1'b0;
      out_slot_q  <= '0;
    end else begin
      start_q <= 1'b0;
      if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            res_fire_q  <= 1'b0;
            res_found_q <= 1'b0;
            res_slot_q  <= '0;
            if (req_i.req_type == REQ_WRITE || !enable_q) begin
              state_q <= ST_DONE;
            end else if (period_q != '0) begin
              // periodic: zero reloads quietly, one fires (if a relay is present) and reloads
              if (tick_q == '0) begin
                tick_q <= cnt_from16(period_q);
              end else if (tick_q == CNT_W'(1)) begin
                res_fire_q <= relay_q;
                tick_q     <= cnt_from16(period_q);
              end else begin
                tick_q <= tick_q - CNT_W'(1);
              end
              state_q <= ST_DONE;
            end else begin
              today_q <= {req_i.now_month, req_i.now_day};
              hour_q  <= req_i.now_hour;
              start_q <= 1'b1;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (tail_tok.go) begin
            sel_q <= tail_tok.sel;
            if (tail_tok.found) begin
              state_q <= ST_APPLY;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_APPLY: begin
          res_fire_q  <= |fire_vec;
          res_found_q <= 1'b1;
          res_slot_q  <= idx_to_slot(sel_q);
          state_q     <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q <= 1'b1;
            out_fire_q  <= res_fire_q;
            out_found_q <= res_found_q;
            out_slot_q  <= res_slot_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // At most one search token is in flight along the chain.
  `RFS_ASSERT(a_one_token, $onehot0(go_vec), "more than one search token in the chain")
  // The token leaves the chain only while the controller waits for it.
  `RFS_ASSERT_IMP(a_tail_in_scan, tail_tok.go, state_q == ST_SCAN, "token left chain outside scan")
  // Only the selected cell may drive the relay.
  `RFS_ASSERT(a_one_fire, $onehot0(fire_vec), "more than one cell fired")
  // A new answer is loaded only from the finishing state.
  `RFS_ASSERT(a_rsp_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE), "answer not from done")

endmodule
